// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, off while reset is held
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// concurrent check that also runs during reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rsst2d_pkg.sv =====
// types, constants and range stepping for the 2d segment tree block
// no dependencies
package rsst2d_pkg;

    localparam int X_SIZE = 64;
    localparam int Y_SIZE = 64;
    localparam int XW     = $clog2(X_SIZE);
    localparam int YW     = $clog2(Y_SIZE);
    localparam int IT_W   = ((XW > YW) ? XW : YW) + 2;
    localparam int AW     = XW + YW + 2;
    localparam int POS_W  = 6;
    localparam int BND_W  = 7;
    localparam int WT_W   = 32;
    localparam int SUM_W  = 64;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_Q_OUTER,
        S_Q_INNER
    } t_state;

    typedef struct packed {
        logic             re;
        logic             we;
        logic [AW-1:0]    addr;
        logic [SUM_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [IT_W-1:0] a;
        logic [IT_W-1:0] b;
        logic            ph;
    } t_iter;

    typedef struct packed {
        t_iter           nxt;
        logic            visit;
        logic            done;
        logic [IT_W-1:0] node;
    } t_step;

    // saturate a bound to the axis size and move it to leaf numbering
    function automatic logic [IT_W-1:0] clamp_node(logic [BND_W-1:0] v, int size);
        logic [IT_W-1:0] r;
        if (int'(v) > size) begin
            r = IT_W'(2 * size);
        end else begin
            r = IT_W'(int'(v) + size);
        end
        return r;
    endfunction

    // one step of the bottom-up range walk, at most one node visited
    function automatic t_step iter_step(t_iter s);
        t_step r;
        r.nxt   = s;
        r.visit = 1'b0;
        r.done  = 1'b0;
        r.node  = '0;
        if (!s.ph && (s.a >= s.b)) begin
            r.done = 1'b1;
        end else if (!s.ph && s.a[0]) begin
            r.visit  = 1'b1;
            r.node   = s.a;
            r.nxt.a  = s.a + IT_W'(1);
            r.nxt.ph = 1'b1;
        end else begin
            if (s.b[0]) begin
                r.visit = 1'b1;
                r.node  = s.b - IT_W'(1);
            end
            r.nxt.a  = s.a >> 1;
            r.nxt.b  = s.b >> 1;
            r.nxt.ph = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/rsst2d_mem.sv =====
// node sum memory, one port, registered read data
// depends on rsst2d_pkg
module rsst2d_mem (
    input  logic                          i_clk,
    input  rsst2d_pkg::t_mem_req          i_req,
    output logic [rsst2d_pkg::SUM_W-1:0]  o_rdata
);

    logic [rsst2d_pkg::SUM_W-1:0] mem [2**rsst2d_pkg::AW];
    logic [rsst2d_pkg::SUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rectangle_sum_segment_tree_2d.sv =====
// 2d segment tree over a 64 by 64 grid: point add, rectangle sum
// depends on rsst2d_pkg and rsst2d_mem
//
// usage: a word is taken at a rising edge with start high and busy low.
// i_cmd = add puts i_weight at (i_x, i_y) and gives no result; a point off
// the grid is dropped. i_cmd = query gives one result: o_sum, the 64 bit
// wrapped sum over [i_x_lo, i_x_hi) by [i_y_lo, i_y_hi), bounds saturated
// to the grid, shown for one cycle with o_valid high.
// timing: all node sums sit in one single port memory, one access a cycle.
// an add does a read and a write for each of 7 x 7 tree nodes. a query
// steps through the column walk and, for each column node it visits, a
// row walk; o_valid comes in the cycle busy drops. busy is high from reset
// for a clearing pass over all 16384 memory entries, one memory entry a
// cycle. the receiver cannot stall: o_sum is valid for exactly one cycle.
module rectangle_sum_segment_tree_2d (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cmd,
    input  logic        [rsst2d_pkg::POS_W-1:0]  i_x,
    input  logic        [rsst2d_pkg::POS_W-1:0]  i_y,
    input  logic signed [rsst2d_pkg::WT_W-1:0]   i_weight,
    input  logic        [rsst2d_pkg::BND_W-1:0]  i_x_lo,
    input  logic        [rsst2d_pkg::BND_W-1:0]  i_x_hi,
    input  logic        [rsst2d_pkg::BND_W-1:0]  i_y_lo,
    input  logic        [rsst2d_pkg::BND_W-1:0]  i_y_hi,
    output logic                                 o_valid,
    output logic signed [rsst2d_pkg::SUM_W-1:0]  o_sum
);

    localparam int XW    = rsst2d_pkg::XW;
    localparam int YW    = rsst2d_pkg::YW;
    localparam int AW    = rsst2d_pkg::AW;
    localparam int SUM_W = rsst2d_pkg::SUM_W;

    rsst2d_pkg::t_state   r_state, n_state;
    logic [AW-1:0]        r_clr, n_clr;
    logic [XW:0]          r_ri, n_ri;
    logic [YW:0]          r_rj, n_rj;
    logic [YW:0]          r_rj0, n_rj0;
    logic [SUM_W-1:0]     r_w, n_w;
    rsst2d_pkg::t_iter    r_outer, n_outer;
    rsst2d_pkg::t_iter    r_inner, n_inner;
    logic [XW:0]          r_row, n_row;
    logic [rsst2d_pkg::IT_W-1:0] r_ylo, n_ylo;
    logic [rsst2d_pkg::IT_W-1:0] r_yhi, n_yhi;
    logic [SUM_W-1:0]     r_acc, n_acc;
    logic                 r_pend, n_pend;
    logic                 r_valid, n_valid;
    logic [SUM_W-1:0]     r_sum, n_sum;

    logic                 accept;
    logic                 add_ok;
    logic                 rj_top;
    logic                 ri_top;
    rsst2d_pkg::t_step    outer_st;
    rsst2d_pkg::t_step    inner_st;
    rsst2d_pkg::t_mem_req mem_req;
    logic [SUM_W-1:0]     rdata;

    rsst2d_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign accept   = start && !busy;
    assign add_ok   = (int'(i_x) < rsst2d_pkg::X_SIZE) && (int'(i_y) < rsst2d_pkg::Y_SIZE);
    assign rj_top   = (r_rj == (YW+1)'(1));
    assign ri_top   = (r_ri == (XW+1)'(1));
    assign outer_st = rsst2d_pkg::iter_step(r_outer);
    assign inner_st = rsst2d_pkg::iter_step(r_inner);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsst2d_pkg::S_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = rsst2d_pkg::S_IDLE;
                end
            end
            rsst2d_pkg::S_IDLE: begin
                if (accept && (i_cmd == rsst2d_pkg::CMD_QUERY)) begin
                    n_state = rsst2d_pkg::S_Q_OUTER;
                end else if (accept && add_ok) begin
                    n_state = rsst2d_pkg::S_ADD_RD;
                end
            end
            rsst2d_pkg::S_ADD_RD: begin
                n_state = rsst2d_pkg::S_ADD_WR;
            end
            rsst2d_pkg::S_ADD_WR: begin
                if (rj_top && ri_top) begin
                    n_state = rsst2d_pkg::S_IDLE;
                end else begin
                    n_state = rsst2d_pkg::S_ADD_RD;
                end
            end
            rsst2d_pkg::S_Q_OUTER: begin
                if (outer_st.done) begin
                    n_state = rsst2d_pkg::S_IDLE;
                end else if (outer_st.visit) begin
                    n_state = rsst2d_pkg::S_Q_INNER;
                end
            end
            rsst2d_pkg::S_Q_INNER: begin
                if (inner_st.done) begin
                    n_state = rsst2d_pkg::S_Q_OUTER;
                end
            end
            default: begin
                n_state = rsst2d_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and memory access
    always_comb begin
        busy          = (r_state != rsst2d_pkg::S_IDLE);
        mem_req.re    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = {r_ri, r_rj};
        mem_req.wdata = rdata + r_w;
        case (r_state)
            rsst2d_pkg::S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = r_clr;
                mem_req.wdata = '0;
            end
            rsst2d_pkg::S_ADD_RD: begin
                mem_req.re = 1'b1;
            end
            rsst2d_pkg::S_ADD_WR: begin
                mem_req.we = 1'b1;
            end
            rsst2d_pkg::S_Q_INNER: begin
                mem_req.re   = inner_st.visit;
                mem_req.addr = {r_row, inner_st.node[YW:0]};
            end
            default: begin
                mem_req.re = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_clr   = r_clr;
        n_ri    = r_ri;
        n_rj    = r_rj;
        n_rj0   = r_rj0;
        n_w     = r_w;
        n_outer = r_outer;
        n_inner = r_inner;
        n_row   = r_row;
        n_ylo   = r_ylo;
        n_yhi   = r_yhi;
        n_acc   = r_pend ? (r_acc + rdata) : r_acc;
        n_pend  = 1'b0;
        n_valid = 1'b0;
        n_sum   = r_sum;
        case (r_state)
            rsst2d_pkg::S_CLEAR: begin
                n_clr = r_clr + AW'(1);
            end
            rsst2d_pkg::S_IDLE: begin
                if (accept) begin
                    n_ri       = (XW+1)'(i_x) + (XW+1)'(rsst2d_pkg::X_SIZE);
                    n_rj       = (YW+1)'(i_y) + (YW+1)'(rsst2d_pkg::Y_SIZE);
                    n_rj0      = (YW+1)'(i_y) + (YW+1)'(rsst2d_pkg::Y_SIZE);
                    n_w        = SUM_W'(i_weight);
                    n_outer.a  = rsst2d_pkg::clamp_node(i_x_lo, rsst2d_pkg::X_SIZE);
                    n_outer.b  = rsst2d_pkg::clamp_node(i_x_hi, rsst2d_pkg::X_SIZE);
                    n_outer.ph = 1'b0;
                    n_ylo      = rsst2d_pkg::clamp_node(i_y_lo, rsst2d_pkg::Y_SIZE);
                    n_yhi      = rsst2d_pkg::clamp_node(i_y_hi, rsst2d_pkg::Y_SIZE);
                    n_acc      = '0;
                end
            end
            rsst2d_pkg::S_ADD_WR: begin
                if (rj_top) begin
                    n_ri = r_ri >> 1;
                    n_rj = r_rj0;
                end else begin
                    n_rj = r_rj >> 1;
                end
            end
            rsst2d_pkg::S_Q_OUTER: begin
                n_outer = outer_st.nxt;
                if (outer_st.done) begin
                    n_valid = 1'b1;
                    n_sum   = r_acc;
                end
                n_row      = outer_st.node[XW:0];
                n_inner.a  = r_ylo;
                n_inner.b  = r_yhi;
                n_inner.ph = 1'b0;
            end
            rsst2d_pkg::S_Q_INNER: begin
                n_inner = inner_st.nxt;
                n_pend  = inner_st.visit;
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsst2d_pkg::S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ri    <= n_ri;
        r_rj    <= n_rj;
        r_rj0   <= n_rj0;
        r_w     <= n_w;
        r_outer <= n_outer;
        r_inner <= n_inner;
        r_row   <= n_row;
        r_ylo   <= n_ylo;
        r_yhi   <= n_yhi;
        r_acc   <= n_acc;
        r_sum   <= n_sum;
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

// ===== rtl/core/rsst2d_chk.sv =====
// port level checks for the 2d segment tree block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module rsst2d_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_cmd,
    input logic o_valid
);

    `CHK_ASSERT_ALWAYS(a_reset_busy, i_clk, !i_rst_n |=> busy, "not busy after reset")
    `CHK_ASSERT(a_valid_after_busy, i_clk, i_rst_n, o_valid |-> $past(busy), "word with no work")
    `CHK_ASSERT(a_add_silent, i_clk, i_rst_n, (start && !busy && !i_cmd) |=> !o_valid, "add gave a word")
    `CHK_ASSERT(a_query_busy, i_clk, i_rst_n, (start && !busy && i_cmd) |=> (busy && !o_valid), "query not taken")

endmodule

bind rectangle_sum_segment_tree_2d rsst2d_chk u_rsst2d_chk (.*);
